// ===== rtl/core/sts_pkg.sv =====
// Shared types, token codes, character classes and keyword table of the SQL token scanner.
package sts_pkg;

    localparam int NWORDS      = 29;
    localparam int MAX_RESULTS = 34;

    // token kinds
    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_IDENT   = 6'd1;
    localparam logic [5:0] K_INT     = 6'd2;
    localparam logic [5:0] K_DEC     = 6'd3;
    localparam logic [5:0] K_STRING  = 6'd4;
    localparam logic [5:0] K_COMMA   = 6'd31;
    localparam logic [5:0] K_SEMI    = 6'd32;
    localparam logic [5:0] K_LPAR    = 6'd33;
    localparam logic [5:0] K_RPAR    = 6'd34;
    localparam logic [5:0] K_STAR    = 6'd35;
    localparam logic [5:0] K_DOT     = 6'd36;
    localparam logic [5:0] K_EQ      = 6'd37;
    localparam logic [5:0] K_NEQ     = 6'd38;
    localparam logic [5:0] K_LT      = 6'd39;
    localparam logic [5:0] K_GT      = 6'd40;
    localparam logic [5:0] K_LTE     = 6'd41;
    localparam logic [5:0] K_GTE     = 6'd42;
    localparam logic [5:0] K_UNKNOWN = 6'd43;

    // characters
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_LESS   = "<";
    localparam logic [7:0] CH_GREAT  = ">";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_LPAR   = "(";
    localparam logic [7:0] CH_RPAR   = ")";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_SPACE  = " ";

    // keyword table, text right-justified
    localparam logic [71:0] KW_TEXT [NWORDS] = '{
        "SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "CREATE", "TABLE",
        "INNER", "JOIN", "ON", "NOT", "NULL", "PRIMARY", "KEY", "INT", "INTEGER",
        "DECIMAL", "FLOAT", "DOUBLE", "VARCHAR", "TEXT", "DATETIME", "DATABASE",
        "DATABASES", "USE", "SHOW", "DROP", "TABLES"
    };
    localparam logic [3:0] KW_LEN [NWORDS] = '{
        4'd6, 4'd4, 4'd5, 4'd6, 4'd4, 4'd6, 4'd6, 4'd5, 4'd5, 4'd4, 4'd2, 4'd3,
        4'd4, 4'd7, 4'd3, 4'd3, 4'd7, 4'd7, 4'd5, 4'd6, 4'd7, 4'd4, 4'd8, 4'd8,
        4'd9, 4'd3, 4'd4, 4'd4, 4'd6
    };
    localparam logic [5:0] KW_KIND [NWORDS] = '{
        6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd20, 6'd21, 6'd21, 6'd21, 6'd22,
        6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30
    };

    // one result record of the token channel
    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  ch;
        logic        vld;
        logic [15:0] line;
        logic [15:0] col;
        logic        tend;
    } t_res;

    function automatic logic [7:0] kw_char(input int k, input int i);
        logic [7:0] c;
        c = 8'd0;
        if (i < int'(KW_LEN[k])) begin
            c = KW_TEXT[k][(int'(KW_LEN[k]) - 1 - i) * 8 +: 8];
        end
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

endpackage

// ===== rtl/core/sts_if.sv =====
// Request and token channel interfaces of the SQL token scanner.
interface sts_req_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_in;
    modport source (output valid, command, char_in, input ready);
    modport sink (input valid, command, char_in, output ready);
endinterface

interface sts_tok_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [7:0]  text_char;
    logic        char_valid;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        token_end;
    logic        run_end;
    modport source (output valid, token_kind, text_char, char_valid, start_line,
                    start_column, token_end, run_end, input ready);
    modport sink (input valid, token_kind, text_char, char_valid, start_line,
                  start_column, token_end, run_end, output ready);
endinterface

// ===== rtl/core/sql_token_scanner_core.sv =====
// Top level of the SQL token scanner: decode, text buffer memory and result sequencer.
//
//  channel | dir | handshake     | payload
//  i_req   | in  | valid / ready | command, char_in
//  o_tok   | out | valid / ready | token_kind, text_char, char_valid, start_line,
//          |     |               | start_column, token_end, run_end
//
// One request at a time: accept, plan, then a buffer read and an output state per
// buffer result (the buffer has a registered read port), an output state per other
// result, then one or two update states. A byte with no result goes from plan to update.
// Reset is synchronous, active low; the buffer is never cleared, only the length.
// A stalled token channel holds the sequencer; results wait in the output register.
module sql_token_scanner_core #(
    parameter int TEXT_MAX = 32,
    parameter int POS_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sts_req_if.sink   i_req,
    sts_tok_if.source o_tok
);
    localparam int DEPTH = TEXT_MAX - 1;
    localparam int LW    = $clog2(TEXT_MAX);
    localparam int AW    = (TEXT_MAX > 2) ? $clog2(TEXT_MAX - 1) : 1;
    localparam logic [LW-1:0]       LMAX  = LW'(TEXT_MAX - 1);
    localparam logic [POS_BITS-1:0] PMAX  = '1;
    localparam logic [POS_BITS-1:0] PONE  = POS_BITS'(1);
    localparam logic [sts_pkg::NWORDS-1:0] ALL_ALIVE = '1;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_DEC, M_STR, M_STR_QUOTE,
        M_MINUS, M_COMMENT, M_BANG, M_LESS, M_GREATER
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE, S_PLAN, S_BUF_RD, S_BUF_WR, S_XTRA, S_UPD, S_UPD2
    } t_state;

    t_state r_state;
    t_mode  r_mode;
    logic   r_cmd;
    logic [7:0] r_ch;
    logic [LW-1:0] r_len, r_idx;
    logic [sts_pkg::NWORDS-1:0] r_alive;
    logic [POS_BITS-1:0] r_cur_line, r_cur_col, r_tok_line, r_tok_col;
    logic [POS_BITS-1:0] r_held_line, r_held_col;
    logic r_xi;
    logic [5:0] r_cnt;

    logic [7:0] r_buf [DEPTH];
    logic [7:0] r_rd;

    logic r_ov;
    sts_pkg::t_res r_out;
    logic r_out_run;

    // plan of the current request
    logic d_buf;
    logic [5:0] d_bkind;
    logic [1:0] d_nx;
    sts_pkg::t_res d_x [2];
    t_mode d_mode;
    logic d_start, d_sid, d_held, d_eof;
    logic [1:0] d_nst;
    logic [7:0] d_s0;

    logic [7:0] c, cu;
    logic [15:0] cur_l16, cur_c16, tok_l16, tok_c16;
    logic do_flush, do_begin;
    logic [5:0] id_kind;

    always_comb begin
        c = r_ch;
        cu = ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
        cur_l16 = 16'(r_cur_line);
        cur_c16 = 16'(r_cur_col);
        tok_l16 = 16'(r_tok_line);
        tok_c16 = 16'(r_tok_col);
        // identifier kind: first live keyword of the stored length
        id_kind = sts_pkg::K_IDENT;
        for (int k = sts_pkg::NWORDS - 1; k >= 0; k--) begin
            if (r_alive[k] && (int'(r_len) == int'(sts_pkg::KW_LEN[k]))) begin
                id_kind = sts_pkg::KW_KIND[k];
            end
        end
    end

    function automatic sts_pkg::t_res mk(input logic [5:0] kind, input logic [7:0] ch,
                                         input logic vld, input logic [15:0] ln,
                                         input logic [15:0] cl, input logic te);
        sts_pkg::t_res r;
        r.kind = kind;
        r.ch   = ch;
        r.vld  = vld;
        r.line = ln;
        r.col  = cl;
        r.tend = te;
        return r;
    endfunction

    // decode the request against the scan state
    always_comb begin
        d_buf = 1'b0;
        d_bkind = sts_pkg::K_IDENT;
        d_nx = 2'd0;
        d_x[0] = '0;
        d_x[1] = '0;
        d_mode = r_mode;
        d_start = 1'b0;
        d_sid = 1'b0;
        d_held = 1'b0;
        d_eof = 1'b0;
        d_nst = 2'd0;
        d_s0 = c;
        do_flush = 1'b0;
        do_begin = 1'b0;
        if (r_cmd) begin
            do_flush = 1'b1;
            d_eof = 1'b1;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (sts_pkg::is_alpha(c) || sts_pkg::is_digit(c) ||
                        c == sts_pkg::CH_UNDER) begin
                        d_sid = 1'b1;
                    end else begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                M_INT: begin
                    if (sts_pkg::is_digit(c)) begin
                        d_nst = 2'd1;
                    end else if (c == sts_pkg::CH_DOT) begin
                        d_held = 1'b1;
                        d_mode = M_INT_DOT;
                    end else begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                M_INT_DOT: begin
                    if (sts_pkg::is_digit(c)) begin
                        d_nst = 2'd2;
                        d_s0 = sts_pkg::CH_DOT;
                        d_mode = M_DEC;
                    end else begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                M_DEC: begin
                    if (sts_pkg::is_digit(c)) begin
                        d_nst = 2'd1;
                    end else begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == sts_pkg::CH_QUOTE) begin
                        d_mode = M_STR_QUOTE;
                    end else begin
                        d_nst = 2'd1;
                    end
                end
                M_STR_QUOTE: begin
                    if (c == sts_pkg::CH_QUOTE) begin
                        d_nst = 2'd1;
                        d_mode = M_STR;
                    end else begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                M_MINUS: begin
                    if (c == sts_pkg::CH_MINUS) begin
                        d_mode = M_COMMENT;
                    end else if (sts_pkg::is_digit(c)) begin
                        d_nst = 2'd2;
                        d_s0 = sts_pkg::CH_MINUS;
                        d_mode = M_INT;
                    end else begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (c == sts_pkg::CH_NL) begin
                        d_mode = M_IDLE;
                    end
                end
                M_BANG, M_LESS, M_GREATER: begin
                    if (c == sts_pkg::CH_EQ) begin
                        d_nx = 2'd2;
                        d_mode = M_IDLE;
                        d_x[1] = mk((r_mode == M_BANG) ? sts_pkg::K_NEQ :
                                    (r_mode == M_LESS) ? sts_pkg::K_LTE : sts_pkg::K_GTE,
                                    sts_pkg::CH_EQ, 1'b1, tok_l16, tok_c16, 1'b1);
                        d_x[0] = d_x[1];
                        d_x[0].ch = (r_mode == M_BANG) ? sts_pkg::CH_BANG :
                                    (r_mode == M_LESS) ? sts_pkg::CH_LESS : sts_pkg::CH_GREAT;
                        d_x[0].tend = 1'b0;
                    end else begin
                        do_flush = 1'b1;
                        do_begin = 1'b1;
                    end
                end
                default: begin
                    do_begin = 1'b1;
                end
            endcase
        end

        // flush the pending token
        if (do_flush) begin
            d_mode = M_IDLE;
            case (r_mode)
                M_IDENT: begin
                    d_buf = 1'b1;
                    d_bkind = id_kind;
                end
                M_INT: begin
                    d_buf = 1'b1;
                    d_bkind = sts_pkg::K_INT;
                end
                M_INT_DOT: begin
                    d_buf = 1'b1;
                    d_bkind = sts_pkg::K_INT;
                    d_x[0] = mk(sts_pkg::K_DOT, sts_pkg::CH_DOT, 1'b1,
                                16'(r_held_line), 16'(r_held_col), 1'b1);
                    d_nx = 2'd1;
                end
                M_DEC: begin
                    d_buf = 1'b1;
                    d_bkind = sts_pkg::K_DEC;
                end
                M_STR, M_STR_QUOTE: begin
                    d_buf = 1'b1;
                    d_bkind = sts_pkg::K_STRING;
                end
                M_MINUS: begin
                    d_x[0] = mk(sts_pkg::K_UNKNOWN, sts_pkg::CH_MINUS, 1'b1,
                                tok_l16, tok_c16, 1'b1);
                    d_nx = 2'd1;
                end
                M_BANG: begin
                    d_x[0] = mk(sts_pkg::K_UNKNOWN, sts_pkg::CH_BANG, 1'b1,
                                tok_l16, tok_c16, 1'b1);
                    d_nx = 2'd1;
                end
                M_LESS: begin
                    d_x[0] = mk(sts_pkg::K_LT, sts_pkg::CH_LESS, 1'b1,
                                tok_l16, tok_c16, 1'b1);
                    d_nx = 2'd1;
                end
                M_GREATER: begin
                    d_x[0] = mk(sts_pkg::K_GT, sts_pkg::CH_GREAT, 1'b1,
                                tok_l16, tok_c16, 1'b1);
                    d_nx = 2'd1;
                end
                default: begin
                end
            endcase
        end

        // end of text marker
        if (d_eof) begin
            d_x[d_nx[0]] = mk(sts_pkg::K_EOF, 8'd0, 1'b0, cur_l16, cur_c16, 1'b1);
            d_nx = d_nx + 2'd1;
        end

        // start the next token
        if (do_begin) begin
            d_mode = M_IDLE;
            if (sts_pkg::is_space(c)) begin
                d_mode = M_IDLE;
            end else if (sts_pkg::is_alpha(c) || c == sts_pkg::CH_UNDER) begin
                d_start = 1'b1;
                d_mode = M_IDENT;
                d_sid = 1'b1;
            end else if (sts_pkg::is_digit(c)) begin
                d_start = 1'b1;
                d_mode = M_INT;
                d_nst = 2'd1;
            end else begin
                case (c)
                    sts_pkg::CH_MINUS: begin
                        d_start = 1'b1;
                        d_mode = M_MINUS;
                    end
                    sts_pkg::CH_QUOTE: begin
                        d_start = 1'b1;
                        d_mode = M_STR;
                    end
                    sts_pkg::CH_BANG: begin
                        d_start = 1'b1;
                        d_mode = M_BANG;
                    end
                    sts_pkg::CH_LESS: begin
                        d_start = 1'b1;
                        d_mode = M_LESS;
                    end
                    sts_pkg::CH_GREAT: begin
                        d_start = 1'b1;
                        d_mode = M_GREATER;
                    end
                    default: begin
                        d_x[d_nx[0]] = mk(
                            (c == sts_pkg::CH_COMMA) ? sts_pkg::K_COMMA :
                            (c == sts_pkg::CH_SEMI)  ? sts_pkg::K_SEMI :
                            (c == sts_pkg::CH_LPAR)  ? sts_pkg::K_LPAR :
                            (c == sts_pkg::CH_RPAR)  ? sts_pkg::K_RPAR :
                            (c == sts_pkg::CH_STAR)  ? sts_pkg::K_STAR :
                            (c == sts_pkg::CH_DOT)   ? sts_pkg::K_DOT :
                            (c == sts_pkg::CH_EQ)    ? sts_pkg::K_EQ : sts_pkg::K_UNKNOWN,
                            c, 1'b1, cur_l16, cur_c16, 1'b1);
                        d_nx = d_nx + 2'd1;
                    end
                endcase
            end
        end
    end

    // state update values
    logic [LW-1:0] lb, n_len;
    logic [sts_pkg::NWORDS-1:0] ab, n_alive;
    logic wr_ok;

    always_comb begin
        lb = d_start ? '0 : r_len;
        ab = d_start ? ALL_ALIVE : r_alive;
        wr_ok = (d_sid || d_nst != 2'd0) && (lb < LMAX);
        n_len = wr_ok ? lb + LW'(1) : lb;
        n_alive = ab;
        if (d_sid && (lb < LMAX)) begin
            for (int k = 0; k < sts_pkg::NWORDS; k++) begin
                if ((int'(lb) >= int'(sts_pkg::KW_LEN[k])) ||
                    (sts_pkg::kw_char(k, int'(lb)) != cu)) begin
                    n_alive[k] = 1'b0;
                end
            end
        end
    end

    // buffer write port
    logic we;
    logic [AW-1:0] wa;
    logic [7:0] wd;

    always_comb begin
        we = 1'b0;
        wa = lb[AW-1:0];
        wd = d_sid ? cu : d_s0;
        if (r_state == S_UPD) begin
            we = wr_ok;
        end else if (r_state == S_UPD2) begin
            we = (r_len < LMAX);
            wa = r_len[AW-1:0];
            wd = r_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_buf[wa] <= wd;
        end
        r_rd <= r_buf[r_idx[AW-1:0]];
    end

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == PMAX) ? v : v + PONE;
    endfunction

    logic out_free, at_limit;
    assign out_free = !r_ov || o_tok.ready;
    assign at_limit = (r_cnt == 6'(sts_pkg::MAX_RESULTS - 1));

    // output register loaded this cycle
    logic ov_set;
    assign ov_set = out_free && ((r_state == S_BUF_WR) || (r_state == S_XTRA));

    logic buf_last;
    assign buf_last = (r_len == '0) || (r_idx + LW'(1) == r_len);

    // sequencer, scan state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode <= M_IDLE;
            r_len <= '0;
            r_alive <= ALL_ALIVE;
            r_cur_line <= PONE;
            r_cur_col <= PONE;
            r_tok_line <= PONE;
            r_tok_col <= PONE;
            r_held_line <= '0;
            r_held_col <= '0;
            r_ov <= 1'b0;
            r_idx <= '0;
            r_xi <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (r_ov && o_tok.ready && !ov_set) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd <= i_req.command;
                        r_ch <= i_req.char_in;
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    r_idx <= '0;
                    r_xi <= 1'b0;
                    r_cnt <= '0;
                    if (d_buf) begin
                        r_state <= S_BUF_RD;
                    end else if (d_nx != 2'd0) begin
                        r_state <= S_XTRA;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_BUF_RD: begin
                    r_state <= S_BUF_WR;
                end
                S_BUF_WR: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_out <= mk(d_bkind, (r_len != '0) ? r_rd : 8'd0, r_len != '0,
                                    tok_l16, tok_c16, buf_last);
                        r_out_run <= (buf_last && d_nx == 2'd0) || at_limit;
                        r_cnt <= r_cnt + 6'd1;
                        r_idx <= r_idx + LW'(1);
                        if (at_limit) begin
                            r_state <= S_UPD;
                        end else if (!buf_last) begin
                            r_state <= S_BUF_RD;
                        end else if (d_nx != 2'd0) begin
                            r_state <= S_XTRA;
                        end else begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_XTRA: begin
                    if (out_free) begin
                        r_ov <= 1'b1;
                        r_out <= d_x[r_xi];
                        r_out_run <= (2'(r_xi) + 2'd1 == d_nx) || at_limit;
                        r_cnt <= r_cnt + 6'd1;
                        r_xi <= 1'b1;
                        if (at_limit || (2'(r_xi) + 2'd1 == d_nx)) begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    if (d_eof) begin
                        r_mode <= M_IDLE;
                        r_len <= '0;
                        r_alive <= ALL_ALIVE;
                        r_cur_line <= PONE;
                        r_cur_col <= PONE;
                        r_tok_line <= PONE;
                        r_tok_col <= PONE;
                        r_held_line <= '0;
                        r_held_col <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_mode <= d_mode;
                        r_len <= n_len;
                        r_alive <= n_alive;
                        if (d_start) begin
                            r_tok_line <= r_cur_line;
                            r_tok_col <= r_cur_col;
                        end
                        if (d_held) begin
                            r_held_line <= r_cur_line;
                            r_held_col <= r_cur_col;
                        end
                        if (r_ch == sts_pkg::CH_NL) begin
                            r_cur_line <= sat_inc(r_cur_line);
                            r_cur_col <= PONE;
                        end else begin
                            r_cur_col <= sat_inc(r_cur_col);
                        end
                        r_state <= (d_nst == 2'd2) ? S_UPD2 : S_IDLE;
                    end
                end
                S_UPD2: begin
                    if (r_len < LMAX) begin
                        r_len <= r_len + LW'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_tok.valid        = r_ov;
    assign o_tok.token_kind   = r_out.kind;
    assign o_tok.text_char    = r_out.ch;
    assign o_tok.char_valid   = r_out.vld;
    assign o_tok.start_line   = r_out.line;
    assign o_tok.start_column = r_out.col;
    assign o_tok.token_end    = r_out.tend;
    assign o_tok.run_end      = r_out_run;

endmodule
